// ===== rtl/dtc_pkg.sv =====
package dtc_pkg;

  localparam logic [31:0] MIN_SEC       = 32'd60;
  localparam logic [31:0] HOUR_SEC      = 32'd3600;
  localparam logic [31:0] DAY_SEC       = 32'd86400;
  localparam logic [31:0] YEAR_SEC      = 32'd365 * DAY_SEC;
  localparam logic [31:0] LEAP_YEAR_SEC = 32'd366 * DAY_SEC;
  localparam logic [31:0] BLK_SEC       = 32'd1461 * DAY_SEC;
  localparam logic [31:0] YEAR_DAYS     = 32'd365;
  localparam logic [31:0] LEAP_DAYS     = 32'd366;
  localparam logic [31:0] BLK_DAYS      = 32'd1461;
  localparam logic [31:0] CENTURY_DAYS  = 32'd36525;
  localparam logic [7:0]  MAX_YEAR      = 8'd100;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  bcd_year;
    logic [7:0]  bcd_month;
    logic [7:0]  bcd_day;
    logic [7:0]  bcd_hour;
    logic [7:0]  bcd_minute;
    logic [7:0]  bcd_second;
    logic [31:0] seconds_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] seconds_out;
    logic [7:0]  out_year;
    logic [4:0]  out_month;
    logic [5:0]  out_day;
    logic [5:0]  out_hour;
    logic [6:0]  out_minute;
    logic [6:0]  out_second;
    logic        ok;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FYB,
    S_FYR,
    S_FMON,
    S_FDAY,
    S_FHR,
    S_FMIN,
    S_FSEC,
    S_BDIV,
    S_BRNG,
    S_BYB,
    S_BYR,
    S_BMON,
    S_BSET,
    S_BHR,
    S_BMIN,
    S_DONE
  } state_t;

  typedef struct packed {
    state_t     st;
    logic [3:0] cnt;
  } ctrl_t;

  // step count minus one for each working state
  function automatic logic [3:0] last_cnt(state_t s);
    logic [3:0] r;
    r = 4'd0;
    case (s)
      S_FYB, S_FDAY, S_FHR, S_BYB, S_BHR: r = 4'd4;
      S_FYR, S_BYR:                        r = 4'd2;
      S_FMON, S_BMON:                      r = 4'd10;
      S_FMIN, S_BMIN:                      r = 4'd5;
      S_BDIV:                              r = 4'd15;
      default:                             r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic state_t succ(state_t s);
    state_t r;
    r = S_IDLE;
    unique case (s)
      S_FYB:   r = S_FYR;
      S_FYR:   r = S_FMON;
      S_FMON:  r = S_FDAY;
      S_FDAY:  r = S_FHR;
      S_FHR:   r = S_FMIN;
      S_FMIN:  r = S_FSEC;
      S_FSEC:  r = S_DONE;
      S_BDIV:  r = S_BRNG;
      S_BRNG:  r = S_BYB;
      S_BYB:   r = S_BYR;
      S_BYR:   r = S_BMON;
      S_BMON:  r = S_BSET;
      S_BSET:  r = S_BHR;
      S_BHR:   r = S_BMIN;
      S_BMIN:  r = S_DONE;
      default: r = S_IDLE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] bcd_dec(logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  // valid for v below 100
  function automatic logic [7:0] dec_bcd(logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [31:0] month_days(logic lp, logic [3:0] m);
    logic [31:0] r;
    r = 32'd31;
    case (m) inside
      4'd1:                  r = lp ? 32'd29 : 32'd28;
      4'd3, 4'd5, 4'd8, 4'd10: r = 32'd30;
      default:               r = 32'd31;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] month_secs(logic lp, logic [3:0] m);
    logic [31:0] r;
    r = 32'd31 * DAY_SEC;
    case (m) inside
      4'd1:                  r = lp ? 32'd29 * DAY_SEC : 32'd28 * DAY_SEC;
      4'd3, 4'd5, 4'd8, 4'd10: r = 32'd30 * DAY_SEC;
      default:               r = 32'd31 * DAY_SEC;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/dtc_if.sv =====
interface dtc_in_if;
  import dtc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtc_out_if;
  import dtc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dtc_alu.sv =====
module dtc_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] y,
  output logic        ge
);
  logic [32:0] s;

  assign s  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + 33'(sub);
  assign y  = s[31:0];
  // carry out of a - b means a >= b
  assign ge = s[32];
endmodule

// ===== rtl/dtc_ctrl.sv =====
module dtc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           opcode,
  input  logic           out_free,
  output dtc_pkg::ctrl_t ctl,
  output logic           ready,
  output logic           load_out
);
  import dtc_pkg::*;

  state_t     st, st_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_IDLE;
      cnt <= 4'd0;
    end else begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: begin
        if (start) st_next = opcode ? S_BDIV : S_FYB;
      end
      S_DONE: begin
        if (out_free) st_next = S_IDLE;
      end
      default: begin
        if (cnt == 4'd0) st_next = succ(st);
      end
    endcase
    if (st_next != st) cnt_next = last_cnt(st_next);
    else if (st == S_IDLE || st == S_DONE) cnt_next = cnt;
    else cnt_next = cnt - 4'd1;
  end

  always_comb begin
    ctl.st   = st;
    ctl.cnt  = cnt;
    ready    = (st == S_IDLE);
    load_out = (st == S_DONE) && out_free;
  end
endmodule

// ===== rtl/bcd_datetime_timestamp_convert_core.sv =====
// bcd date/time <-> seconds since 2000-01-01 00:00:00 converter.
// din carries one request item: opcode 0 turns the bcd fields into a 32-bit
// timestamp, opcode 1 turns seconds_in into bcd fields. dout carries one
// result item per request. both channels use valid/ready; an item moves on a
// clock edge with both high.
// the timestamp arithmetic goes through one 32-bit add / compare-subtract unit that a
// small sequencer steps through shift-add multiplies, restoring divides and
// the year and month walks. din.ready is high only while the sequencer is
// idle, so a new item is taken only after the last one has left the sequencer.
// the result sits in an output register, so the next item is accepted while
// it waits; if dout stalls, the finished result of that next item is held
// inside until the output register frees up.
// rst (synchronous) returns the sequencer to idle and drops dout.valid.
module bcd_datetime_timestamp_convert_core (
  input  logic      clk,
  input  logic      rst,
  dtc_in_if.sink    din,
  dtc_out_if.source dout
);
  import dtc_pkg::*;

  ctrl_t       ctl;
  logic        ready, load_out, out_free, in_fire;
  logic        out_valid;
  out_item_t   out_q;

  logic [31:0] acc, alu_a, alu_b, alu_y;
  logic        alu_sub, alu_ge, en;
  logic [15:0] q;
  logic [16:0] sod;
  logic        opc, okd, okt, bad, go;
  logic [6:0]  yo;
  logic [3:0]  mon;
  logic [4:0]  dm, hh;
  logic [5:0]  mm, ss;
  logic [1:0]  yr;
  logic [3:0]  mo;
  logic [7:0]  res_year;
  logic [4:0]  res_month;
  logic [5:0]  res_day;

  logic [7:0]  yd, md, dd, hd, mind, sd;
  logic        okd_c, okt_c, fleap;
  logic [1:0]  j2;
  logic [3:0]  j4;
  logic [2:0]  k3;
  logic [4:0]  yblk;

  assign in_fire  = din.valid && ready;
  assign out_free = !out_valid || dout.ready;
  assign din.ready  = ready;
  assign dout.valid = out_valid;
  assign dout.data  = out_q;

  dtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (din.valid),
    .opcode   (din.data.opcode),
    .out_free (out_free),
    .ctl      (ctl),
    .ready    (ready),
    .load_out (load_out)
  );

  dtc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y),
    .ge  (alu_ge)
  );

  always_comb begin
    yd    = bcd_dec(din.data.bcd_year);
    md    = bcd_dec(din.data.bcd_month);
    dd    = bcd_dec(din.data.bcd_day);
    hd    = bcd_dec(din.data.bcd_hour);
    mind  = bcd_dec(din.data.bcd_minute);
    sd    = bcd_dec(din.data.bcd_second);
    okd_c = (yd <= MAX_YEAR) && (md >= 8'd1) && (md <= 8'd12)
            && (dd >= 8'd1) && (dd <= 8'd31);
    okt_c = (hd <= 8'd23) && (mind <= 8'd59) && (sd <= 8'd59);
  end

  // loop indexes: j2 and j4 count up while the step counter counts down, k3 follows it down
  assign j2    = 2'(4'd2 - ctl.cnt);
  assign j4    = 4'd10 - ctl.cnt;
  assign k3    = ctl.cnt[2:0];
  assign yblk  = yo[6:2];
  // within 2000..2100 only 2100 breaks the every-fourth-year rule
  assign fleap = (yo[1:0] == 2'd0) && (yo != 7'(MAX_YEAR));

  always_comb begin
    alu_a   = acc;
    alu_b   = 32'd0;
    alu_sub = 1'b0;
    en      = 1'b0;
    case (ctl.st)
      S_FYB: begin
        alu_b = BLK_SEC << k3;
        en    = okd && yblk[k3];
      end
      S_FYR: begin
        alu_b = (j2 == 2'd0) ? LEAP_YEAR_SEC : YEAR_SEC;
        en    = okd && (j2 < yo[1:0]);
      end
      S_FMON: begin
        alu_b = month_secs(fleap, j4);
        en    = okd && ((5'(j4) + 5'd1) < 5'(mon));
      end
      S_FDAY: begin
        alu_b = DAY_SEC << k3;
        en    = okd && dm[k3];
      end
      S_FHR: begin
        alu_b = HOUR_SEC << k3;
        en    = okt && hh[k3];
      end
      S_FMIN: begin
        alu_b = MIN_SEC << k3;
        en    = okt && mm[k3];
      end
      S_FSEC: begin
        alu_b = 32'(ss);
        en    = okt;
      end
      S_BDIV: begin
        alu_b   = DAY_SEC << ctl.cnt;
        alu_sub = 1'b1;
        en      = alu_ge;
      end
      S_BRNG: begin
        alu_a   = 32'(q);
        alu_b   = CENTURY_DAYS;
        alu_sub = 1'b1;
      end
      S_BYB: begin
        alu_b   = BLK_DAYS << k3;
        alu_sub = 1'b1;
        en      = alu_ge;
      end
      S_BYR: begin
        alu_b   = (yr == 2'd0) ? LEAP_DAYS : YEAR_DAYS;
        alu_sub = 1'b1;
        en      = go && alu_ge;
      end
      S_BMON: begin
        alu_b   = month_days(yr == 2'd0, mo);
        alu_sub = 1'b1;
        en      = go && alu_ge;
      end
      S_BHR: begin
        alu_b   = HOUR_SEC << k3;
        alu_sub = 1'b1;
        en      = alu_ge;
      end
      S_BMIN: begin
        alu_b   = MIN_SEC << k3;
        alu_sub = 1'b1;
        en      = alu_ge;
      end
      default: begin
        alu_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc <= din.data.opcode ? din.data.seconds_in : 32'd0;
      opc <= din.data.opcode;
      okd <= okd_c;
      okt <= okt_c;
      yo  <= yd[6:0];
      mon <= md[3:0];
      dm  <= 5'(dd - 8'd1);
      hh  <= hd[4:0];
      mm  <= mind[5:0];
      ss  <= sd[5:0];
    end else if (en) begin
      acc <= alu_y;
    end else if (ctl.st == S_BRNG) begin
      acc <= 32'(q);
    end else if (ctl.st == S_BSET) begin
      acc <= 32'(sod);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q <= 16'd0;
    end else begin
      case (ctl.st)
        S_BDIV, S_BYB, S_BMIN: begin
          if (alu_ge) q[ctl.cnt] <= 1'b1;
        end
        S_BHR: begin
          // hours land in q[12:8], minutes later in q[5:0]
          if (alu_ge) q[{1'b1, k3}] <= 1'b1;
        end
        S_BRNG, S_BSET: begin
          q <= 16'd0;
        end
        default: begin
          q <= q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.st)
      S_BRNG: begin
        sod <= acc[16:0];
        bad <= alu_ge;
        go  <= 1'b1;
        yr  <= 2'd0;
        mo  <= 4'd0;
      end
      S_BYR: begin
        if (en) yr <= yr + 2'd1;
        if (ctl.cnt == 4'd0) go <= 1'b1;
        else if (!en) go <= 1'b0;
      end
      S_BMON: begin
        if (en) mo <= mo + 4'd1;
        else go <= 1'b0;
      end
      S_BSET: begin
        res_year  <= dec_bcd({q[4:0], yr});
        res_month <= 5'(dec_bcd(7'(mo) + 7'd1));
        res_day   <= 6'(dec_bcd(7'(acc[4:0]) + 7'd1));
      end
      default: begin
        go <= go;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (dout.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (!opc) begin
        out_q.seconds_out <= acc;
        out_q.out_year    <= 8'd0;
        out_q.out_month   <= 5'd0;
        out_q.out_day     <= 6'd0;
        out_q.out_hour    <= 6'd0;
        out_q.out_minute  <= 7'd0;
        out_q.out_second  <= 7'd0;
        out_q.ok          <= okd && okt;
      end else begin
        out_q.seconds_out <= 32'd0;
        out_q.out_year    <= bad ? 8'd0 : res_year;
        out_q.out_month   <= bad ? 5'd0 : res_month;
        out_q.out_day     <= bad ? 6'd0 : res_day;
        out_q.out_hour    <= 6'(dec_bcd(7'(q[12:8])));
        out_q.out_minute  <= 7'(dec_bcd(7'(q[5:0])));
        out_q.out_second  <= 7'(dec_bcd(7'(acc[5:0])));
        out_q.ok          <= !bad;
      end
    end
  end
endmodule
